@@ rtl/llsac_pkg.sv @@
// Shared types and codes for the radio link send/acknowledge controller.
// No dependencies; imported by llsac_step, the top level and the testbench.
`timescale 1ns / 1ps

package llsac_pkg;

	// Link states, also the encoding of state_after
	typedef enum logic [1:0] {
		ST_IDLE = 2'd0,
		ST_SEND = 2'd1,
		ST_RECV = 2'd2,
		ST_WACK = 2'd3
	} link_state_t;

	// Event codes
	localparam logic [2:0] EV_TIMEOUT  = 3'd0;
	localparam logic [2:0] EV_TX_DONE  = 3'd1;
	localparam logic [2:0] EV_RX_DONE  = 3'd2;
	localparam logic [2:0] EV_USER_TX  = 3'd3;
	localparam logic [2:0] EV_ACK      = 3'd4;

	// Device classes that change behavior
	localparam logic [1:0] CLASS_A = 2'd0;
	localparam logic [1:0] CLASS_C = 2'd2;

	// Timer commands
	localparam logic [1:0] TMR_NONE  = 2'd0;
	localparam logic [1:0] TMR_SHORT = 2'd1;
	localparam logic [1:0] TMR_LONG  = 2'd2;

	// Send reports
	localparam logic [1:0] REP_NONE = 2'd0;
	localparam logic [1:0] REP_OK   = 2'd1;
	localparam logic [1:0] REP_FAIL = 2'd2;

	// Configuration register indexes
	localparam logic CFG_DEVICE_CLASS  = 1'b0;
	localparam logic CFG_ATTEMPT_LIMIT = 1'b1;

	// Reset values of the configuration registers
	localparam logic [1:0] DEVICE_CLASS_RST  = 2'd2;
	localparam logic [3:0] ATTEMPT_LIMIT_RST = 4'd2;

	// Controller state held between events
	typedef struct packed {
		link_state_t state;
		logic        pending;
		logic        confirmed;
		logic [7:0]  length;
		logic [3:0]  retry;
	} link_regs_t;

	// Commands and reports produced by one event
	typedef struct packed {
		logic       accepted;
		logic       start_transmit;
		logic       enter_receive;
		logic [1:0] timer_action;
		logic [1:0] send_report;
		logic [7:0] frame_length;
		logic       frame_confirmed;
	} step_result_t;

	// Working context while an event is handled
	typedef struct packed {
		link_regs_t   regs;
		step_result_t res;
	} step_ctx_t;

endpackage

@@ rtl/lora_link_send_ack_controller.sv @@
// Radio link send/acknowledge controller: top level with stream ports,
// configuration registers, link state and output buffering. Uses llsac_pkg, llsac_step.
// The result of a request is registered in the output register, or in the skid register while the output stalls.
// Throughput: one request per cycle while the skid register is empty; the state update of the handler sets the pace.
// A two-entry output buffer (output and skid registers) takes one more request while the output stalls.
// Reset (arst_n low, asynchronous): link state idle, no pending send, empty frame,
// retry count zero, device_class 2, attempt_limit 2, output empty.
`timescale 1ns / 1ps

module lora_link_send_ack_controller (
	input  logic        clk,
	input  logic        arst_n,
	// configuration write port
	input  logic        cfg_we,
	input  logic        cfg_index,
	input  logic [3:0]  cfg_data,
	// event request stream
	input  logic        s_tvalid,
	output logic        s_tready,
	input  logic [15:0] s_tdata,   // [7:0] payload_length, [8] confirmed_send, rest zero
	input  logic [2:0]  s_tuser,   // [2:0] func
	// result stream
	output logic        m_tvalid,
	input  logic        m_tready,
	output logic [23:0] m_tdata    // [0] accepted, [1] start_transmit, [2] enter_receive,
	                               // [4:3] timer_action, [6:5] send_report,
	                               // [8:7] state_after, [16:9] frame_length,
	                               // [17] frame_confirmed, [21:18] attempt_index, rest zero
);
	import llsac_pkg::*;

	logic [1:0]   device_class_q;
	logic [3:0]   attempt_limit_q;
	link_regs_t   regs_q;
	link_regs_t   regs_nxt;
	step_result_t res;
	logic [23:0]  res_word;
	logic [23:0]  out_data_q;
	logic [23:0]  skid_data_q;
	logic         out_valid_q;
	logic         skid_valid_q;
	logic         accept;
	logic         out_free;

	llsac_step u_step (
		.device_class   (device_class_q),
		.attempt_limit  (attempt_limit_q),
		.cur            (regs_q),
		.func           (s_tuser),
		.payload_length (s_tdata[7:0]),
		.confirmed_send (s_tdata[8]),
		.nxt            (regs_nxt),
		.res            (res)
	);

	// Pack the result, first field in the lowest bits
	assign res_word = {2'b00, regs_nxt.retry, res.frame_confirmed, res.frame_length,
	                   regs_nxt.state, res.send_report, res.timer_action,
	                   res.enter_receive, res.start_transmit, res.accepted};

	assign s_tready = !skid_valid_q;
	assign accept   = s_tvalid && s_tready;
	assign out_free = !out_valid_q || m_tready;
	assign m_tvalid = out_valid_q;
	assign m_tdata  = out_data_q;

	// Configuration registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			device_class_q  <= DEVICE_CLASS_RST;
			attempt_limit_q <= ATTEMPT_LIMIT_RST;
		end else if (cfg_we) begin
			case (cfg_index)
				CFG_DEVICE_CLASS:  device_class_q  <= cfg_data[1:0];
				CFG_ATTEMPT_LIMIT: attempt_limit_q <= cfg_data;
				default: begin
				end
			endcase
		end
	end

	// Advance link state on each accepted request
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			regs_q <= '{state: ST_IDLE, pending: 1'b0, confirmed: 1'b0,
			            length: 8'd0, retry: 4'd0};
		end else if (accept) begin
			regs_q <= regs_nxt;
		end
	end

	// Output and skid valid flags
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q  <= 1'b0;
			skid_valid_q <= 1'b0;
		end else if (out_free) begin
			if (skid_valid_q) begin
				out_valid_q  <= 1'b1;
				skid_valid_q <= 1'b0;
			end else begin
				out_valid_q  <= accept;
			end
		end else if (accept) begin
			skid_valid_q <= 1'b1;
		end
	end

	// Output and skid payload
	always_ff @(posedge clk) begin
		if (out_free) begin
			if (skid_valid_q) begin
				out_data_q <= skid_data_q;
			end else if (accept) begin
				out_data_q <= res_word;
			end
		end else if (accept) begin
			skid_data_q <= res_word;
		end
	end

endmodule

@@ rtl/llsac_step.sv @@
// Combinational event handler: next link state and commands for one event.
// Depends on llsac_pkg.
`timescale 1ns / 1ps

module llsac_step (
	input  logic [1:0]              device_class,
	input  logic [3:0]              attempt_limit,
	input  llsac_pkg::link_regs_t   cur,
	input  logic [2:0]              func,
	input  logic [7:0]              payload_length,
	input  logic                    confirmed_send,
	output llsac_pkg::link_regs_t   nxt,
	output llsac_pkg::step_result_t res
);
	import llsac_pkg::*;

	// Issue a transmit of the stored frame
	function automatic step_ctx_t do_transmit(step_ctx_t c);
		step_ctx_t o;
		o = c;
		o.res.start_transmit  = 1'b1;
		o.res.frame_length    = c.regs.length;
		o.res.frame_confirmed = c.regs.confirmed;
		return o;
	endfunction

	// Drop the stored frame
	function automatic step_ctx_t clear_frame(step_ctx_t c);
		step_ctx_t o;
		o = c;
		o.regs.confirmed = 1'b0;
		o.regs.length    = 8'd0;
		return o;
	endfunction

	// Send a pending frame and start the short timer
	function automatic step_ctx_t send_pending(step_ctx_t c);
		step_ctx_t o;
		o = do_transmit(c);
		o.regs.pending    = 1'b0;
		o.regs.state      = ST_SEND;
		o.res.timer_action = TMR_SHORT;
		return o;
	endfunction

	// Idle: send what is pending, else listen continuously in class C
	function automatic step_ctx_t idle_handler(step_ctx_t c, logic [1:0] cls);
		step_ctx_t o;
		o = c;
		if (c.regs.pending) begin
			o = send_pending(c);
		end else if (cls == CLASS_C) begin
			o.res.enter_receive = 1'b1;
			o.regs.state        = ST_RECV;
		end
		return o;
	endfunction

	// Receiving: send what is pending
	function automatic step_ctx_t recv_data_avail(step_ctx_t c);
		step_ctx_t o;
		o = c;
		if (c.regs.pending) begin
			o = send_pending(c);
		end
		return o;
	endfunction

	// Data-available dispatch on the current state
	function automatic step_ctx_t data_avail(step_ctx_t c, logic [1:0] cls);
		step_ctx_t o;
		o = c;
		if (c.regs.state == ST_IDLE) begin
			o = idle_handler(c, cls);
		end else if (c.regs.state == ST_RECV) begin
			o = recv_data_avail(c);
		end
		return o;
	endfunction

	step_ctx_t  ctx;
	logic [3:0] last_try;

	// Index of the final allowed attempt; a zero limit acts as one
	assign last_try = (attempt_limit == 4'd0) ? 4'd0 : attempt_limit - 4'd1;

	// Apply the event, follow-on handling in order
	always_comb begin
		ctx      = '0;
		ctx.regs = cur;
		case (func)
			EV_USER_TX: begin
				if (cur.state == ST_IDLE || cur.state == ST_RECV) begin
					ctx.regs.length    = payload_length;
					ctx.regs.confirmed = confirmed_send;
					ctx.regs.pending   = 1'b1;
					ctx                = data_avail(ctx, device_class);
					ctx.regs.retry     = 4'd0;
					ctx.res.accepted   = 1'b1;
				end
			end
			EV_ACK: begin
				ctx.regs.pending = 1'b1;
				ctx              = data_avail(ctx, device_class);
			end
			EV_TIMEOUT, EV_TX_DONE, EV_RX_DONE: begin
				case (cur.state)
					ST_IDLE: begin
						ctx = idle_handler(ctx, device_class);
					end
					ST_SEND: begin
						if (func == EV_TIMEOUT) begin
							ctx.regs.state      = ST_IDLE;
							ctx                 = clear_frame(ctx);
							ctx.res.send_report = REP_FAIL;
							ctx                 = idle_handler(ctx, device_class);
						end else if (func == EV_TX_DONE) begin
							ctx.res.enter_receive = 1'b1;
							if (!cur.confirmed) begin
								ctx.regs.state       = ST_RECV;
								ctx                  = clear_frame(ctx);
								ctx.res.send_report  = REP_OK;
								ctx                  = recv_data_avail(ctx);
								ctx.res.timer_action = TMR_LONG;
							end else begin
								ctx.regs.state       = ST_WACK;
								ctx.res.timer_action = TMR_SHORT;
							end
						end
					end
					ST_RECV: begin
						if (func == EV_TIMEOUT) begin
							if (device_class == CLASS_A) begin
								ctx.regs.state = ST_IDLE;
								ctx            = idle_handler(ctx, device_class);
							end
						end else if (cur.pending) begin
							ctx              = do_transmit(ctx);
							ctx.regs.pending = 1'b0;
							ctx.regs.state   = ST_SEND;
						end
					end
					default: begin
						// awaiting acknowledgement
						if (func == EV_TIMEOUT) begin
							if (cur.retry < last_try) begin
								ctx.regs.retry       = cur.retry + 4'd1;
								ctx                  = do_transmit(ctx);
								ctx.res.timer_action = TMR_SHORT;
							end else begin
								ctx.regs.state      = ST_IDLE;
								ctx                 = clear_frame(ctx);
								ctx                 = idle_handler(ctx, device_class);
								ctx.res.send_report = REP_FAIL;
								ctx                 = data_avail(ctx, device_class);
							end
						end else if (func == EV_TX_DONE) begin
							ctx.res.enter_receive = 1'b1;
							ctx.res.timer_action  = TMR_SHORT;
						end else begin
							ctx.regs.state        = ST_RECV;
							ctx.res.enter_receive = 1'b1;
							ctx                   = clear_frame(ctx);
							ctx.res.send_report   = REP_OK;
							ctx                   = recv_data_avail(ctx);
							ctx.res.timer_action  = TMR_LONG;
						end
					end
				endcase
			end
			default: begin
				// unknown event: nothing changes
			end
		endcase
	end

	assign nxt = ctx.regs;
	assign res = ctx.res;

endmodule

@@ verif/lora_link_send_ack_controller_tb.sv @@
// Self-checking testbench for lora_link_send_ack_controller: a scoreboard class predicts
// each event's commands and the tasks below drive events, stalls and register writes.
// Depends on llsac_pkg and the controller RTL only.
`timescale 1ns / 1ps

module lora_link_send_ack_controller_tb;
	import llsac_pkg::*;

	// Event codes the block must ignore
	localparam logic [2:0] EV_RSVD_FIRST = 3'd5;
	localparam logic [2:0] EV_RSVD_LAST  = 3'd7;
	// Device classes without a package name
	localparam logic [1:0] CLASS_B    = 2'd1;
	localparam logic [1:0] CLASS_RSVD = 2'd3;
	// Cycles with no handshake at all before the run is declared hung
	localparam int STALL_LIMIT = 2000;
	localparam int PHASE_EVENTS = 90;

	// Result fields, most significant first, matching m_tdata[21:0]
	typedef struct packed {
		logic [3:0] attempt;
		logic       frame_conf;
		logic [7:0] frame_len;
		logic [1:0] state_after;
		logic [1:0] report;
		logic [1:0] timer;
		logic       enter_rx;
		logic       start_tx;
		logic       accepted;
	} link_outcome_t;

	class link_ctrl_scoreboard;
		link_state_t   st;
		bit            pending;
		bit            conf_mode;
		bit [7:0]      len;
		bit [3:0]      retry;
		bit [1:0]      dev_class;
		bit [3:0]      att_limit;
		link_outcome_t res;
		link_outcome_t expected_outcomes[$];
		int            mismatches;

		function new();
			st = ST_IDLE;
			pending = 0;
			conf_mode = 0;
			len = '0;
			retry = '0;
			dev_class = DEVICE_CLASS_RST;
			att_limit = ATTEMPT_LIMIT_RST;
			mismatches = 0;
		endfunction

		function void set_reg(logic idx, logic [3:0] val);
			if (idx == CFG_DEVICE_CLASS) dev_class = val[1:0];
			else att_limit = val;
		endfunction

		function void transmit();
			res.start_tx = 1'b1;
			res.frame_len = len;
			res.frame_conf = conf_mode;
		endfunction

		function void clear_frame();
			conf_mode = 0;
			len = '0;
		endfunction

		// Idle state: send what is pending, else class C listens
		function void idle_entry();
			if (pending) begin
				transmit();
				pending = 0;
				st = ST_SEND;
				res.timer = TMR_SHORT;
			end else if (dev_class == CLASS_C) begin
				res.enter_rx = 1'b1;
				st = ST_RECV;
			end
		endfunction

		function void recv_entry();
			if (pending) begin
				transmit();
				pending = 0;
				st = ST_SEND;
				res.timer = TMR_SHORT;
			end
		endfunction

		function void data_ready();
			if (st == ST_IDLE) idle_entry();
			else if (st == ST_RECV) recv_entry();
		endfunction

		// Advance the link state by one accepted request and queue its outcome
		function void note_event(logic [2:0] func, logic [7:0] plen, logic pconf);
			logic [4:0] lim;
			res = '0;
			case (func)
				EV_USER_TX: begin
					if (st == ST_IDLE || st == ST_RECV) begin
						len = plen;
						conf_mode = pconf;
						pending = 1;
						data_ready();
						retry = '0;
						res.accepted = 1'b1;
					end
				end
				EV_ACK: begin
					pending = 1;
					data_ready();
				end
				EV_TIMEOUT, EV_TX_DONE, EV_RX_DONE: begin
					case (st)
						ST_IDLE: idle_entry();
						ST_SEND: begin
							if (func == EV_TIMEOUT) begin
								st = ST_IDLE;
								clear_frame();
								res.report = REP_FAIL;
								idle_entry();
							end else if (func == EV_TX_DONE) begin
								res.enter_rx = 1'b1;
								if (!conf_mode) begin
									st = ST_RECV;
									clear_frame();
									res.report = REP_OK;
									recv_entry();
									res.timer = TMR_LONG;
								end else begin
									st = ST_WACK;
									res.timer = TMR_SHORT;
								end
							end
						end
						ST_RECV: begin
							if (func == EV_TIMEOUT) begin
								if (dev_class == CLASS_A) begin
									st = ST_IDLE;
									idle_entry();
								end
							end else if (pending) begin
								transmit();
								pending = 0;
								st = ST_SEND;
							end
						end
						ST_WACK: begin
							if (func == EV_TIMEOUT) begin
								// a zero limit behaves as a single attempt
								lim = (att_limit == 0) ? 5'd1 : {1'b0, att_limit};
								if ({1'b0, retry} < lim - 5'd1) begin
									retry = retry + 4'd1;
									transmit();
									res.timer = TMR_SHORT;
								end else begin
									st = ST_IDLE;
									clear_frame();
									idle_entry();
									res.report = REP_FAIL;
									data_ready();
								end
							end else if (func == EV_TX_DONE) begin
								res.enter_rx = 1'b1;
								res.timer = TMR_SHORT;
							end else begin
								st = ST_RECV;
								res.enter_rx = 1'b1;
								clear_frame();
								res.report = REP_OK;
								recv_entry();
								res.timer = TMR_LONG;
							end
						end
					endcase
				end
				default: ;
			endcase
			res.state_after = st;
			res.attempt = retry;
			expected_outcomes.push_back(res);
		endfunction

		task report_mismatch(string what);
			mismatches++;
			if (mismatches <= 200) $display("MISMATCH at %0t ns: %s", $time, what);
		endtask

		task check_field(string name, int unsigned got, int unsigned want);
			if (got != want)
				report_mismatch($sformatf("%s got %0d, expected %0d", name, got, want));
		endtask

		// Compare one result with the oldest outcome still waiting
		task check_outcome(logic [23:0] data);
			link_outcome_t got;
			link_outcome_t want;
			if (expected_outcomes.size() == 0) begin
				report_mismatch($sformatf("result 0x%06h with no request waiting", data));
				return;
			end
			want = expected_outcomes.pop_front();
			got = data[21:0];
			check_field("accepted", got.accepted, want.accepted);
			check_field("start_transmit", got.start_tx, want.start_tx);
			check_field("enter_receive", got.enter_rx, want.enter_rx);
			check_field("timer_action", got.timer, want.timer);
			check_field("send_report", got.report, want.report);
			check_field("state_after", got.state_after, want.state_after);
			check_field("frame_length", got.frame_len, want.frame_len);
			check_field("frame_confirmed", got.frame_conf, want.frame_conf);
			check_field("attempt_index", got.attempt, want.attempt);
		endtask
	endclass

	logic        clk = 1'b0;
	logic        arst_n;
	logic        cfg_we;
	logic        cfg_index;
	logic [3:0]  cfg_data;
	logic        s_tvalid;
	logic        s_tready;
	logic [15:0] s_tdata;   // [7:0] payload_length, [8] confirmed_send, rest zero
	logic [2:0]  s_tuser;   // [2:0] func
	logic        m_tvalid;
	logic        m_tready;
	logic [23:0] m_tdata;   // [0] accepted .. [21:18] attempt_index, see link_outcome_t
	logic        gaps_on;
	int          quiet_cycles = 0;

	link_ctrl_scoreboard sb = new();

	lora_link_send_ack_controller DUT (
		.clk(clk),
		.arst_n(arst_n),
		.cfg_we(cfg_we),
		.cfg_index(cfg_index),
		.cfg_data(cfg_data),
		.s_tvalid(s_tvalid),
		.s_tready(s_tready),
		.s_tdata(s_tdata),
		.s_tuser(s_tuser),
		.m_tvalid(m_tvalid),
		.m_tready(m_tready),
		.m_tdata(m_tdata)
	);

	always begin
		#6 clk = 1'b1;
		#6 clk = 1'b0;
	end

	// Sample both handshakes at the rising edge
	always @(posedge clk) begin
		if (arst_n) begin
			if (s_tvalid && s_tready) sb.note_event(s_tuser, s_tdata[7:0], s_tdata[8]);
			if (m_tvalid && m_tready) sb.check_outcome(m_tdata);
		end
	end

	// Abort when nothing moves for too long
	always @(posedge clk) begin
		if (arst_n) begin
			if ((s_tvalid && s_tready) || (m_tvalid && m_tready) || cfg_we) begin
				quiet_cycles <= 0;
			end else if (quiet_cycles >= STALL_LIMIT) begin
				$display("DONE: errors detected");
				$finish;
			end else begin
				quiet_cycles <= quiet_cycles + 1;
			end
		end
	end

	// Result side: stall in random bursts while gaps are enabled
	always begin
		@(negedge clk);
		if (gaps_on && $urandom_range(0, 7) == 0) begin
			m_tready <= 1'b0;
			repeat ($urandom_range(1, 17)) @(negedge clk);
		end
		m_tready <= 1'b1;
	end

	// Present one request and hold it until taken; entered and left at a falling edge
	task send_event(logic [2:0] func, logic [7:0] plen, logic pconf);
		if (gaps_on && $urandom_range(0, 5) == 0) begin
			s_tvalid <= 1'b0;
			repeat ($urandom_range(1, 17)) @(negedge clk);
		end
		s_tvalid <= 1'b1;
		s_tuser <= func;
		s_tdata <= {7'd0, pconf, plen};
		@(posedge clk);
		while (!s_tready) @(posedge clk);
		@(negedge clk);
	endtask

	// Stop requests and wait until every outcome has come back
	task drain_results();
		s_tvalid <= 1'b0;
		while (sb.expected_outcomes.size() != 0) @(posedge clk);
		repeat (3) @(negedge clk);
	endtask

	task write_reg(logic idx, logic [3:0] val);
		cfg_we <= 1'b1;
		cfg_index <= idx;
		cfg_data <= val;
		@(negedge clk);
		cfg_we <= 1'b0;
		sb.set_reg(idx, val);
	endtask

	initial begin
		logic [1:0] phase_class [6];
		logic [3:0] phase_limit [6];
		logic [2:0] func;
		logic [7:0] plen;
		logic       pconf;
		int         roll;

		arst_n = 1'b0;
		cfg_we = 1'b0;
		cfg_index = CFG_DEVICE_CLASS;
		cfg_data = '0;
		s_tvalid = 1'b0;
		s_tdata = '0;
		s_tuser = EV_TIMEOUT;
		m_tready = 1'b0;
		gaps_on = 1'b1;
		repeat (9) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		// Directed: reset settings (class C, two attempts)
		send_event(EV_RSVD_FIRST, 8'hFF, 1'b1);
		send_event(EV_TIMEOUT, 8'h00, 1'b0);
		send_event(EV_USER_TX, 8'hFF, 1'b1);
		send_event(EV_USER_TX, 8'h00, 1'b0);      // refused while sending
		send_event(EV_ACK, 8'h00, 1'b0);          // ack while sending sets pending only
		send_event(EV_TIMEOUT, 8'h00, 1'b0);      // failure resends the cleared frame
		send_event(EV_TX_DONE, 8'h00, 1'b0);
		send_event(EV_USER_TX, 8'h5A, 1'b1);
		send_event(EV_TX_DONE, 8'h00, 1'b0);
		send_event(EV_ACK, 8'h00, 1'b0);
		send_event(EV_TX_DONE, 8'h00, 1'b0);
		send_event(EV_TIMEOUT, 8'h00, 1'b0);      // one retry
		send_event(EV_TIMEOUT, 8'h00, 1'b0);      // attempts exhausted
		send_event(EV_RSVD_LAST, 8'h00, 1'b0);
		drain_results();

		// Directed: class A with a zero attempt limit
		write_reg(CFG_DEVICE_CLASS, {2'b00, CLASS_A});
		write_reg(CFG_ATTEMPT_LIMIT, 4'd0);
		send_event(EV_USER_TX, 8'hA5, 1'b1);
		send_event(EV_TX_DONE, 8'h00, 1'b0);
		send_event(EV_TIMEOUT, 8'h00, 1'b0);
		send_event(EV_ACK, 8'h00, 1'b0);
		send_event(EV_TX_DONE, 8'h00, 1'b0);
		send_event(EV_TIMEOUT, 8'h00, 1'b0);
		drain_results();

		// Directed: reserved class code behaves as class B
		write_reg(CFG_DEVICE_CLASS, {2'b00, CLASS_RSVD});
		write_reg(CFG_ATTEMPT_LIMIT, 4'd15);
		send_event(EV_TIMEOUT, 8'h00, 1'b0);
		send_event(EV_USER_TX, 8'h01, 1'b1);
		send_event(EV_TX_DONE, 8'h00, 1'b0);
		send_event(EV_RX_DONE, 8'h00, 1'b0);
		send_event(EV_TIMEOUT, 8'h00, 1'b0);
		drain_results();

		phase_class = '{CLASS_B, CLASS_C, CLASS_A, CLASS_RSVD, CLASS_C, 2'd0};
		phase_limit = '{4'd1, 4'd15, 4'd2, 4'd7, 4'd15, 4'd0};
		phase_class[5] = 2'($urandom_range(0, 3));
		phase_limit[5] = 4'($urandom_range(0, 15));

		// Random phases, event choice steered by the predicted state
		for (int p = 0; p < 6; p++) begin
			gaps_on = (p != 5);
			write_reg(CFG_DEVICE_CLASS, {2'b00, phase_class[p]});
			write_reg(CFG_ATTEMPT_LIMIT, phase_limit[p]);
			for (int n = 0; n < PHASE_EVENTS; n++) begin
				plen = 8'($urandom_range(0, 255));
				pconf = 1'($urandom_range(0, 1));
				roll = $urandom_range(0, 99);
				if ($urandom_range(0, 9) < 2) begin
					func = 3'($urandom_range(0, 7));
				end else begin
					case (sb.st)
						ST_IDLE: func = roll < 70 ? EV_USER_TX : (roll < 85 ? EV_TIMEOUT : EV_ACK);
						ST_SEND: func = roll < 75 ? EV_TX_DONE : (roll < 90 ? EV_TIMEOUT :
							(roll < 95 ? EV_ACK : EV_USER_TX));
						ST_RECV: func = roll < 50 ? EV_USER_TX : (roll < 70 ? EV_RX_DONE :
							(roll < 85 ? EV_TIMEOUT : EV_ACK));
						default: func = roll < 85 ? EV_TIMEOUT : (roll < 93 ? EV_RX_DONE :
							(roll < 97 ? EV_TX_DONE : EV_ACK));
					endcase
				end
				send_event(func, plen, pconf);
				if (gaps_on && $urandom_range(0, 59) == 0) drain_results();
			end
			drain_results();
		end

		// Let any stray result show up, then judge
		repeat (4) @(posedge clk);
		if (sb.expected_outcomes.size() != 0)
			sb.report_mismatch($sformatf("%0d results never arrived",
				sb.expected_outcomes.size()));
		if (sb.mismatches == 0) begin
			$display("DONE: 0 errors");
		end else begin
			$display("DONE: errors detected");
		end
		$finish;
	end

endmodule

@@ files.f @@
rtl/llsac_pkg.sv
rtl/llsac_step.sv
rtl/lora_link_send_ack_controller.sv
verif/lora_link_send_ack_controller_tb.sv
